@@ design/spc_pkg.sv @@
// Shared constants and a helper function for the skin pixel classifier.
package spc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_HUE_LOW  = 2'd0;
    localparam logic [1:0] REG_HUE_HIGH = 2'd1;
    localparam logic [1:0] REG_HUE_FS   = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] HUE_LOW_RESET  = 8'd25;
    localparam logic [7:0] HUE_HIGH_RESET = 8'd230;
    localparam logic [8:0] HUE_FS_RESET   = 9'd360;

    // Luma and chroma conversion weights, 14-bit fraction.
    localparam logic [21:0] Y_WEIGHT_R = 22'd4899;
    localparam logic [21:0] Y_WEIGHT_G = 22'd9617;
    localparam logic [21:0] Y_WEIGHT_B = 22'd1868;
    localparam logic [21:0] Y_ROUND    = 22'd8192;
    localparam logic signed [24:0] CR_WEIGHT = 25'sd11682;
    localparam logic signed [24:0] CB_WEIGHT = 25'sd9241;
    localparam logic signed [24:0] C_OFFSET  = 25'sd2105344;

    // Chroma line bounds, slopes and intercepts in Q16.
    localparam logic signed [27:0] L3_SLOPE = 28'sd103953;
    localparam logic signed [27:0] L3_ICPT  = 28'sd1310720;
    localparam logic signed [27:0] L4_SLOPE = 28'sd22597;
    localparam logic signed [27:0] L4_ICPT  = 28'sd4994295;
    localparam logic signed [27:0] L5_SLOPE = 28'sd299185;
    localparam logic signed [27:0] L5_ICPT  = 28'sd15372465;
    localparam logic signed [27:0] L6_SLOPE = 28'sd75366;
    localparam logic signed [27:0] L6_ICPT  = 28'sd19775488;
    localparam logic signed [27:0] L7_SLOPE = 28'sd149796;
    localparam logic signed [27:0] L7_ICPT  = 28'sd28367258;

    // Saturate a 14-bit fraction sum to an 8-bit chroma value.
    function automatic logic [7:0] clamp_shift14(input logic signed [24:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v[24:22] != 3'd0)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[21:14];
        end
        return r;
    endfunction

endpackage

@@ design/skin_pixel_classifier.sv @@
// Top level of the skin pixel classifier: a three-stage pixel pipeline.
//
// One BGR pixel per transaction enters on the input channel and one result
// leaves on the output channel; a pixel passes unchanged when the RGB rule,
// the five Cr/Cb line bounds hold and the hue lies outside the hue window, else it is black.
// The pipeline takes one pixel per clock whenever its input is ready and has
// three register stages: luma, extremes and hue numerator first,
// then chroma and the hue cross products, then the bound compares into the
// output register. Each stage holds its own valid bit and advances whenever
// the stage after it is empty or advancing, so bubbles close up during a
// stall and the input stays ready until all three stages hold a waiting
// pixel. The hue registers
// are written through the configuration channel, which is always ready, and
// should be changed only while the pipeline is empty.
module skin_pixel_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel_blue,
    input  logic [7:0] pixel_green,
    input  logic [7:0] pixel_red,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red,
    output logic       is_skin
);
    import spc_pkg::*;

    // Configuration registers.
    logic [7:0] hue_low_reg;
    logic [7:0] hue_high_reg;
    logic [8:0] hue_fs_reg;

    // Stage enables.
    logic en1;
    logic en2;
    logic en3;

    // Stage 1 registers.
    logic        v1_reg;
    logic [7:0]  r1_reg, g1_reg, b1_reg;
    logic [7:0]  y1_reg;
    logic        rgb1_reg;
    logic [16:0] num1_reg;
    logic [7:0]  d1_reg;
    logic [16:0] lofs1_reg;
    logic [16:0] hifs1_reg;

    // Stage 2 registers.
    logic        v2_reg;
    logic [7:0]  r2_reg, g2_reg, b2_reg;
    logic        rgb2_reg;
    logic [7:0]  cr2_reg;
    logic [7:0]  cb2_reg;
    logic [24:0] hlhs2_reg;
    logic [24:0] hlo2_reg;
    logic [24:0] hhi2_reg;

    // Output registers.
    logic        v3_reg;
    logic [7:0]  r3_reg, g3_reg, b3_reg;
    logic        skin3_reg;

    // Stage 1 combinational values.
    logic [21:0] y_sum;
    logic [7:0]  y_next;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d_raw;
    logic [7:0]  drg;
    logic        rule_one;
    logic        rule_two;
    logic        rgb_next;
    logic signed [18:0] num_s;
    logic [16:0] num_next;
    logic [7:0]  d_next;
    logic [8:0]  fs_eff;

    // Stage 2 combinational values.
    logic signed [8:0]  dr;
    logic signed [8:0]  db;
    logic signed [24:0] cr_sum;
    logic signed [24:0] cb_sum;
    logic [7:0]  cr_next;
    logic [7:0]  cb_next;

    // Stage 3 combinational values.
    logic signed [27:0] cr_q;
    logic signed [27:0] cb_s;
    logic e3, e4, e5, e6, e7;
    logic hue_ok;
    logic skin_next;

    // Ready chains back from the output; a stage moves when the next can take it.
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign cfg_ready = 1'b1;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= HUE_LOW_RESET;
            hue_high_reg <= HUE_HIGH_RESET;
            hue_fs_reg   <= HUE_FS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HUE_LOW:  hue_low_reg  <= cfg_data[7:0];
                REG_HUE_HIGH: hue_high_reg <= cfg_data[7:0];
                REG_HUE_FS:   hue_fs_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Stage 1: luma sum, extremes, RGB rule and hue numerator.
    always_comb
    begin
        y_sum = Y_WEIGHT_R * 22'(pixel_red) + Y_WEIGHT_G * 22'(pixel_green)
              + Y_WEIGHT_B * 22'(pixel_blue) + Y_ROUND;
        y_next = y_sum[21:14];

        mx = (pixel_red > pixel_green)
           ? ((pixel_red > pixel_blue) ? pixel_red : pixel_blue)
           : ((pixel_green > pixel_blue) ? pixel_green : pixel_blue);
        mn = (pixel_red < pixel_green)
           ? ((pixel_red < pixel_blue) ? pixel_red : pixel_blue)
           : ((pixel_green < pixel_blue) ? pixel_green : pixel_blue);
        d_raw = mx - mn;
        drg = (pixel_red > pixel_green) ? (pixel_red - pixel_green)
                                        : (pixel_green - pixel_red);

        rule_one = (pixel_red > 8'd95) && (pixel_green > 8'd40) && (pixel_blue > 8'd20)
                && (d_raw > 8'd15) && (drg > 8'd15)
                && (pixel_red > pixel_green) && (pixel_red > pixel_blue);
        rule_two = (pixel_red > 8'd220) && (pixel_green > 8'd210) && (pixel_blue > 8'd170)
                && (drg <= 8'd15) && (pixel_red > pixel_blue) && (pixel_green > pixel_blue);
        rgb_next = rule_one || rule_two;

        // Hue is num/d degrees; a flat pixel has hue 0 over a divisor of 1.
        if (d_raw == 8'd0)
        begin
            num_s  = 19'sd0;
            d_next = 8'd1;
        end
        else if (mx == pixel_red)
        begin
            num_s = 19'sd60 * (19'(pixel_green) - 19'(pixel_blue));
            if (num_s < 0)
            begin
                num_s = num_s + 19'sd360 * 19'(d_raw);
            end
            d_next = d_raw;
        end
        else if (mx == pixel_green)
        begin
            num_s  = 19'sd60 * (19'(pixel_blue) - 19'(pixel_red)) + 19'sd120 * 19'(d_raw);
            d_next = d_raw;
        end
        else
        begin
            num_s  = 19'sd60 * (19'(pixel_red) - 19'(pixel_green)) + 19'sd240 * 19'(d_raw);
            d_next = d_raw;
        end
        num_next = num_s[16:0];

        fs_eff = (hue_fs_reg == 9'd0) ? 9'd1 : hue_fs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            r1_reg    <= pixel_red;
            g1_reg    <= pixel_green;
            b1_reg    <= pixel_blue;
            y1_reg    <= y_next;
            rgb1_reg  <= rgb_next;
            num1_reg  <= num_next;
            d1_reg    <= d_next;
            lofs1_reg <= 17'(hue_low_reg) * 17'(fs_eff);
            hifs1_reg <= 17'(hue_high_reg) * 17'(fs_eff);
        end
    end

    // Stage 2: saturated chroma and hue cross products.
    always_comb
    begin
        dr      = signed'({1'b0, r1_reg}) - signed'({1'b0, y1_reg});
        db      = signed'({1'b0, b1_reg}) - signed'({1'b0, y1_reg});
        cr_sum  = 25'(dr) * CR_WEIGHT + C_OFFSET;
        cb_sum  = 25'(db) * CB_WEIGHT + C_OFFSET;
        cr_next = clamp_shift14(cr_sum);
        cb_next = clamp_shift14(cb_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;
            rgb2_reg  <= rgb1_reg;
            cr2_reg   <= cr_next;
            cb2_reg   <= cb_next;
            hlhs2_reg <= 25'(num1_reg) * 25'd255;
            hlo2_reg  <= 25'(lofs1_reg) * 25'(d1_reg);
            hhi2_reg  <= 25'(hifs1_reg) * 25'(d1_reg);
        end
    end

    // Stage 3: chroma line bounds and hue window, exact in Q16.
    always_comb
    begin
        cr_q = signed'({4'd0, cr2_reg, 16'd0});
        cb_s = signed'({20'd0, cb2_reg});
        e3 = cr_q <= L3_SLOPE * cb_s + L3_ICPT;
        e4 = cr_q >= L4_SLOPE * cb_s + L4_ICPT;
        e5 = cr_q >= L5_ICPT - L5_SLOPE * cb_s;
        e6 = cr_q <= L6_ICPT - L6_SLOPE * cb_s;
        e7 = cr_q <= L7_ICPT - L7_SLOPE * cb_s;
        hue_ok = (hlhs2_reg < hlo2_reg) || (hlhs2_reg > hhi2_reg);
        skin_next = rgb2_reg && e3 && e4 && e5 && e6 && e7 && hue_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            r3_reg    <= skin_next ? r2_reg : 8'd0;
            g3_reg    <= skin_next ? g2_reg : 8'd0;
            b3_reg    <= skin_next ? b2_reg : 8'd0;
            skin3_reg <= skin_next;
        end
    end

    // Output transaction.
    assign out_valid = v3_reg;
    assign out_red   = r3_reg;
    assign out_green = g3_reg;
    assign out_blue  = b3_reg;
    assign is_skin   = skin3_reg;

endmodule

@@ tb/tb_skin_pixel_classifier.sv @@
// Self-checking testbench for the skin pixel classifier pipeline.
module tb_skin_pixel_classifier;
    import spc_pkg::*;

    // Register index that the block does not decode.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int PIPE_LATENCY   = 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 100;

    // Chroma line bounds in Q16: Cr * 2^16 compared against slope * Cb + intercept.
    localparam longint CHROMA_ONE   = 65536;
    localparam longint UPPER_SLOPE  = 103953;
    localparam longint UPPER_ICPT   = 1310720;
    localparam longint LOWER_SLOPE  = 22597;
    localparam longint LOWER_ICPT   = 4994295;
    localparam longint STEEP_SLOPE  = -299185;
    localparam longint STEEP_ICPT   = 15372465;
    localparam longint FALL_SLOPE   = -75366;
    localparam longint FALL_ICPT    = 19775488;
    localparam longint FAR_SLOPE    = -149796;
    localparam longint FAR_ICPT     = 28367258;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       skin;
    } skin_result_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [8:0] cfg_data = 9'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] pixel_blue = 8'd0;
    logic [7:0] pixel_green = 8'd0;
    logic [7:0] pixel_red = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       is_skin;

    // Shadow copy of the hue registers.
    logic [7:0] hue_low_cfg  = HUE_LOW_RESET;
    logic [7:0] hue_high_cfg = HUE_HIGH_RESET;
    logic [8:0] hue_fs_cfg   = HUE_FS_RESET;

    pixel_t       pending_pixels[$];
    skin_result_t expected_results[$];

    bit steady = 1'b0;
    int sent_count = 0;
    int accepted_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    skin_pixel_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_blue  (pixel_blue),
        .pixel_green (pixel_green),
        .pixel_red   (pixel_red),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_blue    (out_blue),
        .out_green   (out_green),
        .out_red     (out_red),
        .is_skin     (is_skin)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Round a 14-bit fraction sum down to a chroma level, saturated to 0..255.
    function automatic longint chroma_level(int sum);
        if (sum < 0)
        begin
            return 0;
        end
        if ((sum >>> 14) > 255)
        begin
            return 255;
        end
        return sum >>> 14;
    endfunction

    // Expected output for one pixel under the current hue settings.
    function automatic skin_result_t classify_pixel(pixel_t px);
        int r, g, b, mx, mn, diff_rg, luma;
        longint cr, cb, cr_q16, hue_num, span, scale, hue_lhs;
        bit rgb_ok, chroma_ok, hue_ok, branch_a, branch_b;
        skin_result_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        diff_rg = (r > g) ? r - g : g - r;

        // Two-branch RGB rule: ordinary lighting, then strong flash lighting.
        branch_a = r > 95 && g > 40 && b > 20 && (mx - mn) > 15 && diff_rg > 15
                   && r > g && r > b;
        branch_b = r > 220 && g > 210 && b > 170 && diff_rg <= 15 && r > b && g > b;
        rgb_ok = branch_a || branch_b;

        // Integer luma/chroma conversion followed by five line bounds.
        luma = (r * 4899 + g * 9617 + b * 1868 + 8192) >>> 14;
        cr = chroma_level((r - luma) * 11682 + 2105344);
        cb = chroma_level((b - luma) * 9241 + 2105344);
        cr_q16 = cr * CHROMA_ONE;
        chroma_ok = cr_q16 <= UPPER_SLOPE * cb + UPPER_ICPT
                    && cr_q16 >= LOWER_SLOPE * cb + LOWER_ICPT
                    && cr_q16 >= STEEP_SLOPE * cb + STEEP_ICPT
                    && cr_q16 <= FALL_SLOPE * cb + FALL_ICPT
                    && cr_q16 <= FAR_SLOPE * cb + FAR_ICPT;

        // Hue as the fraction hue_num / span degrees, compared without rounding.
        span = mx - mn;
        scale = (hue_fs_cfg == 9'd0) ? 1 : longint'(hue_fs_cfg);
        if (span == 0)
        begin
            hue_num = 0;
            span = 1;
        end
        else if (mx == r)
        begin
            hue_num = 60 * (g - b);
            if (hue_num < 0)
            begin
                hue_num = hue_num + 360 * span;
            end
        end
        else if (mx == g)
        begin
            hue_num = 60 * (b - r) + 120 * span;
        end
        else
        begin
            hue_num = 60 * (r - g) + 240 * span;
        end
        hue_lhs = hue_num * 255;
        hue_ok = hue_lhs < longint'(hue_low_cfg) * scale * span
                 || hue_lhs > longint'(hue_high_cfg) * scale * span;

        res.skin = rgb_ok && chroma_ok && hue_ok;
        res.blue = res.skin ? px.blue : 8'd0;
        res.green = res.skin ? px.green : 8'd0;
        res.red = res.skin ? px.red : 8'd0;
        return res;
    endfunction

    // Random pixel, biased toward both branches of the RGB rule.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            px.red = 8'($urandom_range(96, 255));
            px.green = 8'($urandom_range(41, px.red - 1));
            px.blue = 8'($urandom_range(21, px.green));
        end
        else if (pick == 4)
        begin
            px.red = 8'($urandom_range(221, 255));
            px.green = 8'($urandom_range(211, 255));
            px.blue = 8'($urandom_range(170, ((px.red < px.green) ? px.red : px.green) - 1));
        end
        else
        begin
            px = pixel_t'(24'($urandom));
        end
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Sender: presents queued pixels, with random gaps between transactions.
    always @(negedge clk)
    begin
        pixel_t px;
        if (sent_count == accepted_count)
        begin
            if (send_gap > 0 && !steady)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() != 0 && !steady && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() != 0)
            begin
                px = pending_pixels.pop_front();
                pixel_blue <= px.blue;
                pixel_green <= px.green;
                pixel_red <= px.red;
                in_valid <= 1'b1;
                sent_count++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: drops ready in random bursts.
    always @(negedge clk)
    begin
        if (!steady && stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: tracks register writes, predicts accepted pixels, checks results.
    always @(posedge clk)
    begin
        skin_result_t want;
        bit moved;
        moved = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            moved = 1'b1;
            case (cfg_index)
                REG_HUE_LOW:  hue_low_cfg = cfg_data[7:0];
                REG_HUE_HIGH: hue_high_cfg = cfg_data[7:0];
                REG_HUE_FS:   hue_fs_cfg = cfg_data;
                default:      ;
            endcase
        end

        if (out_valid && out_ready)
        begin
            moved = 1'b1;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected (rgb %0d,%0d,%0d skin %0d)",
                                          out_red, out_green, out_blue, is_skin));
            end
            else
            begin
                want = expected_results.pop_front();
                if (is_skin !== want.skin)
                    report_mismatch($sformatf("is_skin got %0d expected %0d", is_skin, want.skin));
                if (out_blue !== want.blue)
                    report_mismatch($sformatf("out_blue got %0d expected %0d", out_blue, want.blue));
                if (out_green !== want.green)
                    report_mismatch($sformatf("out_green got %0d expected %0d",
                                              out_green, want.green));
                if (out_red !== want.red)
                    report_mismatch($sformatf("out_red got %0d expected %0d", out_red, want.red));
            end
        end

        if (in_valid && in_ready)
        begin
            moved = 1'b1;
            expected_results.insert(expected_results.size(),
                                    classify_pixel('{blue: pixel_blue, green: pixel_green,
                                                     red: pixel_red}));
            accepted_count++;
        end

        // Watchdog on cycles with no transaction on any channel.
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** skin_pixel_classifier: FAILED **");
            $finish;
        end
    end

    task automatic queue_pixel(int blue, int green, int red);
        pixel_t px;
        px.blue = blue[7:0];
        px.green = green[7:0];
        px.red = red[7:0];
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    // Wait until the pipeline is empty and every result is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || sent_count != accepted_count
               || expected_results.size() != 0);
        repeat (PIPE_LATENCY + 1) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [8:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_hue_setting(logic [8:0] low, logic [8:0] high, logic [8:0] full);
        wait_drained();
        write_reg(REG_HUE_LOW, low);
        write_reg(REG_HUE_HIGH, high);
        write_reg(REG_HUE_FS, full);
    endtask

    task automatic run_random_pixels(int count);
        repeat (count) pending_pixels.insert(pending_pixels.size(), random_pixel());
        wait_drained();
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pixels under the reset settings.
        queue_pixel(0, 0, 0);           // flat black, hue taken as zero
        queue_pixel(255, 255, 255);     // flat white
        queue_pixel(90, 120, 200);      // typical skin tone
        queue_pixel(120, 90, 200);      // red maximum with hue wrapping past 360
        queue_pixel(200, 230, 240);     // flash branch, hue inside the window
        queue_pixel(180, 235, 245);     // flash branch
        queue_pixel(171, 211, 221);     // flash branch just past its thresholds
        queue_pixel(170, 210, 220);     // flash branch on its thresholds
        queue_pixel(21, 41, 96);        // ordinary branch just past its thresholds
        queue_pixel(20, 40, 95);        // ordinary branch on its thresholds
        queue_pixel(50, 200, 100);      // green maximum
        queue_pixel(200, 50, 100);      // blue maximum
        queue_pixel(50, 200, 200);      // red and green tie for maximum
        queue_pixel(200, 100, 200);     // red and blue tie for maximum
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(60, 80, 250);       // chroma near saturation
        queue_pixel(100, 140, 180);
        queue_pixel(255, 0, 255);
        run_random_pixels(230);

        // Window that covers every hue, so none passes; bit 8 of the data is dropped for the limits.
        apply_hue_setting(9'h100, 9'h0FF, 9'd360);
        run_random_pixels(50);
        run_random_pixels(50);

        // Smallest full scale with inverted limits; an undecoded index is ignored.
        wait_drained();
        write_reg(REG_UNUSED, 9'h1FF);
        apply_hue_setting(9'h0FF, 9'h000, 9'd1);
        run_random_pixels(100);

        // Zero full scale behaves as one.
        apply_hue_setting(9'd128, 9'd200, 9'd0);
        run_random_pixels(100);

        // Full scale above 360 keeps the scaled hue below 255.
        apply_hue_setting(9'd40, 9'd120, 9'd511);
        run_random_pixels(100);

        repeat (2)
        begin
            apply_hue_setting(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                              9'($urandom_range(0, 511)));
            run_random_pixels(100);
        end

        // Closing stretch at full rate with no idling on either side.
        steady = 1'b1;
        apply_hue_setting(9'(HUE_LOW_RESET), 9'(HUE_HIGH_RESET),
                          9'($urandom_range(300, 360)));
        run_random_pixels(200);

        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("** skin_pixel_classifier: PASSED **");
        end
        else
        begin
            $display("** skin_pixel_classifier: FAILED **");
        end
        $finish;
    end

endmodule
